/* rtl/itag_pkg.sv */
// shared constants and types for the iou track id assigner
package itag_pkg;

    // default sizes
    localparam int DEF_MAX_TRACKS = 64;
    localparam int DEF_MAX_DETS   = 32;
    localparam int DEF_COORD_BITS = 12;
    localparam int DEF_MISS_BITS  = 8;

    // register and output field widths
    localparam int MAXMISS_W      = 8;
    localparam logic [MAXMISS_W-1:0] MAXMISS_RST = 8'd5;
    localparam int ID_W           = 6;
    localparam int SLOT_MAXW      = 8;

    // best match found by the iou scan
    typedef struct packed {
        logic                 found;
        logic                 hit;
        logic [SLOT_MAXW-1:0] slot;
    } t_iou_res;

endpackage

/* rtl/itag_iou.sv */
// iou pipeline with running best-match selection over a track scan
module itag_iou
    import itag_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int TW         = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_clear,
    input  logic                    i_vld,
    input  logic                    i_live,
    input  logic [TW-1:0]           i_slot,
    input  logic [4*COORD_BITS-1:0] i_det_box,
    input  logic [4*COORD_BITS-1:0] i_trk_box,
    output logic                    o_busy,
    output t_iou_res                o_res
);
    localparam int C  = COORD_BITS;
    localparam int EW = C + 1;
    localparam int IW = 2 * EW;
    localparam int AW = 2 * C;
    localparam int UW = 2 * C + 1;
    localparam int PW = IW + UW;

    logic [EW-1:0] dx, dy, dw, dh, tx, ty, tw, th;
    logic [EW-1:0] lft, rgt, top, bot, iw, ih;
    logic [AW-1:0] ap, aq;

    logic          r_a_t, r_b_t, r_c_t, r_d_t;
    logic          r_a_live, r_b_live, r_c_live, r_d_live;
    logic [TW-1:0] r_a_slot, r_b_slot, r_c_slot, r_d_slot;
    logic [EW-1:0] r_a_iw, r_a_ih;
    logic [AW-1:0] r_a_ap, r_a_aq;
    logic [IW-1:0] r_b_i, r_c_i, r_d_i;
    logic [UW-1:0] r_b_s, r_c_u, r_d_u;
    logic [PW-1:0] r_d_p1, r_d_p2;

    logic [IW-1:0] r_bi;
    logic [UW-1:0] r_bu;
    logic [TW-1:0] r_best;
    logic          r_found;
    logic          upd;
    logic [IW+3:0] thr_i, thr_u;

    // box edges
    always_comb begin
        dx  = EW'(i_det_box[4*C-1:3*C]);
        dy  = EW'(i_det_box[3*C-1:2*C]);
        dw  = EW'(i_det_box[2*C-1:C]);
        dh  = EW'(i_det_box[C-1:0]);
        tx  = EW'(i_trk_box[4*C-1:3*C]);
        ty  = EW'(i_trk_box[3*C-1:2*C]);
        tw  = EW'(i_trk_box[2*C-1:C]);
        th  = EW'(i_trk_box[C-1:0]);
        lft = (dx > tx) ? dx : tx;
        rgt = ((dx + dw) < (tx + tw)) ? (dx + dw) : (tx + tw);
        top = (dy > ty) ? dy : ty;
        bot = ((dy + dh) < (ty + th)) ? (dy + dh) : (ty + th);
        iw  = (lft < rgt) ? (rgt - lft) : '0;
        ih  = (top < bot) ? (bot - top) : '0;
        ap  = dw[C-1:0] * dh[C-1:0];
        aq  = tw[C-1:0] * th[C-1:0];
    end

    // tag pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_t <= 1'b0;
            r_b_t <= 1'b0;
            r_c_t <= 1'b0;
            r_d_t <= 1'b0;
        end else begin
            r_a_t <= i_vld;
            r_b_t <= r_a_t;
            r_c_t <= r_b_t;
            r_d_t <= r_c_t;
        end
    end

    // extents, intersection, union, cross products
    always_ff @(posedge i_clk) begin
        r_a_live <= i_live;
        r_a_slot <= i_slot;
        r_a_iw   <= iw;
        r_a_ih   <= ih;
        r_a_ap   <= ap;
        r_a_aq   <= aq;
        r_b_live <= r_a_live;
        r_b_slot <= r_a_slot;
        r_b_i    <= r_a_iw * r_a_ih;
        r_b_s    <= UW'(r_a_ap) + UW'(r_a_aq);
        r_c_live <= r_b_live;
        r_c_slot <= r_b_slot;
        r_c_i    <= r_b_i;
        r_c_u    <= r_b_s - r_b_i[UW-1:0];
        r_d_live <= r_c_live;
        r_d_slot <= r_c_slot;
        r_d_i    <= r_c_i;
        r_d_u    <= r_c_u;
        r_d_p1   <= PW'(r_c_i) * PW'(r_bu);
        r_d_p2   <= PW'(r_bi) * PW'(r_c_u);
    end

    // strictly better ratio replaces the best
    assign upd = r_d_t && r_d_live && (r_d_i != '0) && (r_d_p1 > r_d_p2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_bi    <= '0;
            r_bu    <= UW'(1);
            r_best  <= '0;
            r_found <= 1'b0;
        end else if (upd) begin
            r_bi    <= r_d_i;
            r_bu    <= r_d_u;
            r_best  <= r_d_slot;
            r_found <= 1'b1;
        end
    end

    // match threshold iou > 0.3
    assign thr_i = (IW+4)'({r_bi, 3'b000}) + (IW+4)'({r_bi, 1'b0});
    assign thr_u = (IW+4)'({r_bu, 1'b0}) + (IW+4)'(r_bu);

    assign o_busy      = r_a_t | r_b_t | r_c_t | r_d_t;
    assign o_res.found = r_found;
    assign o_res.hit   = r_found && (thr_i > thr_u);
    assign o_res.slot  = SLOT_MAXW'(r_best);

endmodule

/* rtl/iou_track_id_assigner_core.sv */
// top level of the iou track id assigner
// Each detection box is matched against the previous frame's tracks by walking
// the slot memory, one entry at a time, through a pipelined IoU unit whose
// best-ratio compare keeps the running best match; an item without a box that
// does not end the frame is taken without a scan. The item that ends a frame
// starts an aging sweep of the slot memory, then emits one result per buffered
// detection, skipping occupied slots while searching free slots for new tracks.
// Input is taken again once the last result sits in the output register.
module iou_track_id_assigner_core
    import itag_pkg::*;
#(
    parameter int MAX_TRACKS = DEF_MAX_TRACKS,
    parameter int MAX_DETS   = DEF_MAX_DETS,
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int MISS_BITS  = DEF_MISS_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [MAXMISS_W-1:0]  i_cfg_max_miss,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_has_box,
    input  logic [COORD_BITS-1:0] i_box_x,
    input  logic [COORD_BITS-1:0] i_box_y,
    input  logic [COORD_BITS-1:0] i_box_w,
    input  logic [COORD_BITS-1:0] i_box_h,
    input  logic                  i_last_in_frame,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [ID_W-1:0]       o_track_id,
    output logic                  o_is_new,
    output logic                  o_no_slot,
    output logic                  o_frame_overflow,
    output logic                  o_last
);
    localparam int TW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int TCW = $clog2(MAX_TRACKS + 1);
    localparam int DW  = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
    localparam int DCW = $clog2(MAX_DETS + 1);
    localparam int BW  = 4 * COORD_BITS;
    localparam int SW  = MISS_BITS + BW;
    localparam int DEW = BW + TW + 1;
    localparam int MW  = (MISS_BITS > MAXMISS_W) ? MISS_BITS : MAXMISS_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DETW = 3'd2;
    localparam logic [2:0] S_AGE  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    // storage
    logic [SW-1:0]  slot_mem [MAX_TRACKS];
    logic [BW-1:0]  pend_mem [MAX_TRACKS];
    logic [DEW-1:0] det_mem  [MAX_DETS];

    logic [2:0]            r_state;
    logic [MAXMISS_W-1:0]  r_max_miss;
    logic [MAX_TRACKS-1:0] r_valid, r_hit;
    logic [DCW-1:0]        r_det_cnt, r_d;
    logic                  r_ovf, r_flast, r_ph;
    logic [BW-1:0]         r_box;
    logic [TCW-1:0]        r_k, r_fp;
    logic                  r_t1, r_sv1;
    logic [TW-1:0]         r_k1;
    logic [SW-1:0]         r_srd;
    logic [BW-1:0]         r_prd;
    logic [DEW-1:0]        r_drd;

    logic                  r_o_valid, r_o_new, r_o_ns, r_o_ovf, r_o_last;
    logic [ID_W-1:0]       r_o_id;

    logic                  in_acc, rd_en, issue, scan_done, busy, can_out;
    logic [TW-1:0]         kk, fpi;
    t_iou_res              res;
    logic [MISS_BITS-1:0]  miss;
    logic [BW-1:0]         sbox, dbox;
    logic [TW-1:0]         dslot;
    logic                  dmatch, dlast;
    logic                  s_we;
    logic [TW-1:0]         s_wa;
    logic [SW-1:0]         s_wd;
    logic                  emit, e_new, e_ns;
    logic [TW+ID_W-1:0]    e_idw;
    logic [TW-1:0]         e_id;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign kk          = r_k[TW-1:0];
    assign fpi         = r_fp[TW-1:0];
    assign rd_en       = (r_k < TCW'(MAX_TRACKS)) && !r_ph &&
                         (r_state == S_SCAN || r_state == S_AGE);
    assign issue       = rd_en && (r_state == S_SCAN);
    assign scan_done   = (r_k == TCW'(MAX_TRACKS)) && !r_t1 && !busy;
    assign can_out     = !r_o_valid || i_out_ready;

    // read data fields
    assign miss   = r_srd[SW-1:BW];
    assign sbox   = r_srd[BW-1:0];
    assign dbox   = r_drd[DEW-1:TW+1];
    assign dslot  = r_drd[TW:1];
    assign dmatch = r_drd[0];
    assign dlast  = (r_d + DCW'(1)) == r_det_cnt;

    // slot and pending memories
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_srd <= slot_mem[kk];
            r_prd <= pend_mem[kk];
        end
        if (s_we) begin
            slot_mem[s_wa] <= s_wd;
        end
        if (r_state == S_DETW && res.hit) begin
            pend_mem[res.slot[TW-1:0]] <= r_box;
        end
    end

    // detection buffer
    always_ff @(posedge i_clk) begin
        if (r_state == S_DETW) begin
            det_mem[r_det_cnt[DW-1:0]] <= {r_box, res.slot[TW-1:0], res.hit};
        end
        if (r_state == S_OUT && !r_ph) begin
            r_drd <= det_mem[r_d[DW-1:0]];
        end
    end

    // issue tag aligned with the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= 1'b0;
        end else begin
            r_t1 <= issue;
        end
        r_sv1 <= r_valid[kk];
        r_k1  <= kk;
    end

    itag_iou #(
        .COORD_BITS(COORD_BITS),
        .TW        (TW)
    ) u_iou (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (in_acc),
        .i_vld    (r_t1),
        .i_live   (r_sv1),
        .i_slot   (r_k1),
        .i_det_box(r_box),
        .i_trk_box(sbox),
        .o_busy   (busy),
        .o_res    (res)
    );

    // slot memory write: aging sweep and new track allocation
    always_comb begin
        s_we  = 1'b0;
        s_wa  = kk;
        s_wd  = r_srd;
        emit  = 1'b0;
        e_new = 1'b0;
        e_ns  = 1'b0;
        e_id  = '0;
        if (r_state == S_AGE && r_ph && r_valid[kk]) begin
            if (r_hit[kk]) begin
                s_we = 1'b1;
                s_wd = {{MISS_BITS{1'b0}}, r_prd};
            end else if (MW'(miss) >= MW'(r_max_miss)) begin
                s_we = 1'b0;
            end else if (miss != {MISS_BITS{1'b1}}) begin
                s_we = 1'b1;
                s_wd = {miss + MISS_BITS'(1), sbox};
            end
        end
        if (r_state == S_OUT && r_ph && can_out) begin
            if (dmatch) begin
                emit = 1'b1;
                e_id = dslot;
            end else if (r_fp == TCW'(MAX_TRACKS)) begin
                emit = 1'b1;
                e_ns = 1'b1;
            end else if (!r_valid[fpi]) begin
                emit  = 1'b1;
                e_new = 1'b1;
                e_id  = fpi;
                s_we  = 1'b1;
                s_wa  = fpi;
                s_wd  = {{MISS_BITS{1'b0}}, dbox};
            end
        end
    end
    assign e_idw = {{ID_W{1'b0}}, e_id};

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_max_miss <= MAXMISS_RST;
            r_valid   <= '0;
            r_hit     <= '0;
            r_det_cnt <= '0;
            r_ovf     <= 1'b0;
            r_flast   <= 1'b0;
            r_ph      <= 1'b0;
            r_k       <= '0;
            r_d       <= '0;
            r_fp      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_miss <= i_cfg_max_miss;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_flast <= i_last_in_frame;
                        r_k     <= '0;
                        r_ph    <= 1'b0;
                        if (i_has_box && r_det_cnt < DCW'(MAX_DETS)) begin
                            r_box   <= {i_box_x, i_box_y, i_box_w, i_box_h};
                            r_state <= S_SCAN;
                        end else begin
                            if (i_has_box) begin
                                r_ovf <= 1'b1;
                            end
                            if (i_last_in_frame) begin
                                r_state <= S_AGE;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (rd_en) begin
                        r_ph <= 1'b1;
                        r_k  <= r_k + TCW'(1);
                    end else begin
                        r_ph <= 1'b0;
                    end
                    if (scan_done) begin
                        r_state <= S_DETW;
                    end
                end
                S_DETW: begin
                    if (res.hit) begin
                        r_hit[res.slot[TW-1:0]] <= 1'b1;
                    end
                    r_det_cnt <= r_det_cnt + DCW'(1);
                    r_k       <= '0;
                    r_ph      <= 1'b0;
                    r_state   <= r_flast ? S_AGE : S_IDLE;
                end
                S_AGE: begin
                    if (!r_ph) begin
                        if (r_k == TCW'(MAX_TRACKS)) begin
                            r_state <= S_OUT;
                            r_d     <= '0;
                            r_fp    <= '0;
                        end else begin
                            r_ph <= 1'b1;
                        end
                    end else begin
                        if (r_valid[kk]) begin
                            if (r_hit[kk]) begin
                                r_hit[kk] <= 1'b0;
                            end else if (MW'(miss) >= MW'(r_max_miss)) begin
                                r_valid[kk] <= 1'b0;
                            end
                        end
                        r_ph <= 1'b0;
                        r_k  <= r_k + TCW'(1);
                    end
                end
                S_OUT: begin
                    if (r_det_cnt == '0) begin
                        r_ovf   <= 1'b0;
                        r_state <= S_IDLE;
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        if (!dmatch && r_fp != TCW'(MAX_TRACKS) && r_valid[fpi]) begin
                            r_fp <= r_fp + TCW'(1);
                        end
                        if (emit) begin
                            if (e_new) begin
                                r_valid[fpi] <= 1'b1;
                                r_fp         <= r_fp + TCW'(1);
                            end
                            r_ph <= 1'b0;
                            if (dlast) begin
                                r_det_cnt <= '0;
                                r_ovf     <= 1'b0;
                                r_state   <= S_IDLE;
                            end else begin
                                r_d <= r_d + DCW'(1);
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
        if (emit) begin
            r_o_id   <= e_idw[ID_W-1:0];
            r_o_new  <= e_new;
            r_o_ns   <= e_ns;
            r_o_ovf  <= r_ovf;
            r_o_last <= dlast;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_track_id       = r_o_id;
    assign o_is_new         = r_o_new;
    assign o_no_slot        = r_o_ns;
    assign o_frame_overflow = r_o_ovf;
    assign o_last           = r_o_last;

endmodule

/* rtl/itag_chk.sv */
// port-level checker for the iou track id assigner, bound to the top level
module itag_chk
    import itag_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input logic            i_last_in_frame,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input logic [ID_W-1:0] o_track_id,
    input logic            o_is_new,
    input logic            o_no_slot
);
    // a pending result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_track_id))
        else $error("result changed while stalled");

    // a result without a slot carries id zero and no new track
    a_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_slot |-> o_track_id == '0 && !o_is_new)
        else $error("no_slot result carries a track");

    // a frame end always leaves the block busy in the cycle after it is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last_in_frame |=> !o_in_ready)
        else $error("frame end taken without a busy cycle");

endmodule

bind iou_track_id_assigner_core itag_chk u_itag_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_last_in_frame(i_last_in_frame),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_track_id     (o_track_id),
    .o_is_new       (o_is_new),
    .o_no_slot      (o_no_slot)
);
